@@ rtl/core/aob_pkg.sv @@
// shared constants, codes and types for the angular occlusion buffer
package aob_pkg;

	localparam int BUCKET_BITS = 11;
	localparam int NBUCKETS = 1 << BUCKET_BITS;
	localparam int ROW_W = 128;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_PAINT  = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;
	localparam logic [1:0] REQ_QUERY  = 2'd3;

	localparam logic [31:0] ONE_FX = 32'h0001_0000;
	localparam logic [31:0] DEPTH_MAX = 32'hFFFF_FFFF;
	localparam logic [31:0] SLOPE_MIN = 32'h8000_0000;
	localparam logic [31:0] SLOPE_MAX = 32'h7FFF_FFFF;

	// row layout: floor depth, floor slope, ceiling depth, ceiling slope
	localparam logic [ROW_W-1:0] CLR_ROW = {DEPTH_MAX, SLOPE_MIN, DEPTH_MAX, SLOPE_MAX};

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_STA,
		ST_WA,
		ST_STB,
		ST_WB,
		ST_RD,
		ST_CHK,
		ST_OUT
	} state_t;

	typedef logic [BUCKET_BITS-1:0] bucket_t;

endpackage

@@ rtl/core/angular_occlusion_buffer_core.sv @@
// Angular occlusion buffer: floor and ceiling clip tables over angle buckets.
// Finish and rejected queries go straight to the output state; clear first sweeps the table.
// Paint and query run their two slope divisions (shorter when numerator or divisor is zero),
// then read and check each bucket in turn, a query checking the centre bucket first.
// One word at a time: a new word is taken only when the sequencer is idle.
// After reset the tables are swept to their reset values, no input taken.
module angular_occlusion_buffer_core import aob_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        eye_height_we,
	input  logic [31:0] eye_height,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic        is_floor,
	input  logic [31:0] height_z,
	input  logic [30:0] actor_height,
	input  logic [31:0] near_dist,
	input  logic [31:0] far_dist,
	input  logic [10:0] first_bucket,
	input  logic [10:0] last_bucket,
	input  logic [10:0] centre_bucket,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hidden
);

	state_t state_q, state_d;

	logic [31:0] eye_q;
	logic        active_q;
	logic [1:0]  req_q;
	logic        floor_q;
	logic [31:0] z_q;
	logic [30:0] ah_q;
	logic [31:0] near_q;
	logic [31:0] far_q;
	bucket_t     cur_q;
	bucket_t     end_q;
	bucket_t     centre_q;
	logic        ctr_q;
	logic        hid_q;
	logic        rep_q;
	logic signed [31:0] sa_q;
	logic signed [31:0] sb_q;

	logic               accept;
	logic               div_start;
	logic               div_done;
	logic signed [33:0] div_num;
	logic [31:0]        div_den;
	logic [31:0]        div_quo;
	logic signed [33:0] h_base;
	logic signed [33:0] h_top;

	logic               ram_we;
	bucket_t            ram_addr;
	logic [ROW_W-1:0]   ram_wdata;
	logic [ROW_W-1:0]   ram_rdata;

	logic [31:0]        f_depth, c_depth;
	logic signed [31:0] f_slope, c_slope;
	logic signed [31:0] paint_s;
	logic               better;
	logic               covered;
	logic               early_out;
	logic               out_free;

	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign early_out = (req_type == REQ_FINISH)
		|| (req_type == REQ_QUERY && (!active_q || near_dist <= ONE_FX));

	// slope numerators
	assign h_base = {{2{z_q[31]}}, z_q} - {{2{eye_q[31]}}, eye_q};
	assign h_top = h_base + {3'b000, ah_q};

	// divider operands: first top/near slope, then far or bottom slope
	always_comb begin
		if (state_q == ST_STA) begin
			div_num = (req_q == REQ_QUERY) ? h_top : h_base;
			div_den = near_q;
		end else begin
			div_num = h_base;
			div_den = (req_q == REQ_QUERY) ? near_q : far_q;
		end
	end

	aob_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// table row split
	assign f_depth = ram_rdata[127:96];
	assign f_slope = ram_rdata[95:64];
	assign c_depth = ram_rdata[63:32];
	assign c_slope = ram_rdata[31:0];

	// paint slope and replacement test
	always_comb begin
		if (floor_q) begin
			paint_s = (sa_q < sb_q) ? sa_q : sb_q;
			better = (paint_s > f_slope) || (paint_s == f_slope && far_q < f_depth);
		end else begin
			paint_s = (sa_q > sb_q) ? sa_q : sb_q;
			better = (paint_s < c_slope) || (paint_s == c_slope && far_q < c_depth);
		end
	end

	// query cover test: sa is top slope, sb is bottom slope
	assign covered = ((near_q > f_depth) && (sa_q <= f_slope))
		|| ((near_q > c_depth) && (sb_q >= c_slope));

	aob_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NBUCKETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (cur_q == '1) begin
					state_d = rep_q ? ST_OUT : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_CLEAR) begin
						state_d = ST_CLR;
					end else if (early_out) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_STA;
					end
				end
			end
			ST_STA: state_d = ST_WA;
			ST_WA: begin
				if (div_done) begin
					state_d = ST_STB;
				end
			end
			ST_STB: state_d = ST_WB;
			ST_WB: begin
				if (div_done) begin
					state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_CHK;
			ST_CHK: begin
				if (req_q == REQ_QUERY) begin
					if (!covered) begin
						state_d = ST_OUT;
					end else if (ctr_q) begin
						state_d = ST_RD;
					end else if (cur_q == end_q) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_RD;
					end
				end else if (cur_q == end_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		div_start = 1'b0;
		ram_we = 1'b0;
		ram_addr = cur_q;
		ram_wdata = CLR_ROW;
		unique case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_STA, ST_STB: begin
				div_start = 1'b1;
			end
			ST_RD: begin
				ram_addr = (req_q == REQ_QUERY && ctr_q) ? centre_q : cur_q;
			end
			ST_CHK: begin
				ram_we = (req_q == REQ_PAINT) && better;
				ram_wdata = floor_q ? {far_q, paint_s, ram_rdata[63:0]}
					: {ram_rdata[127:64], far_q, paint_s};
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// state, control and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			eye_q <= '0;
			active_q <= 1'b0;
			cur_q <= '0;
			rep_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (eye_height_we) begin
				eye_q <= eye_height;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			// bucket pointer: sweep, span walk
			if (state_q == ST_CLR) begin
				cur_q <= cur_q + 1'b1;
			end else if (accept) begin
				cur_q <= (req_type == REQ_CLEAR) ? '0 : bucket_t'(first_bucket);
				rep_q <= 1'b1;
				if (req_type == REQ_CLEAR) begin
					active_q <= 1'b0;
				end else if (req_type == REQ_FINISH) begin
					active_q <= 1'b1;
				end
			end else if (state_q == ST_CHK && !(req_q == REQ_QUERY && ctr_q)) begin
				cur_q <= cur_q + 1'b1;
			end
		end
	end

	// captured word, slopes and answer
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			floor_q <= is_floor;
			z_q <= height_z;
			ah_q <= actor_height;
			near_q <= near_dist;
			far_q <= far_dist;
			end_q <= bucket_t'(last_bucket);
			centre_q <= bucket_t'(centre_bucket);
			ctr_q <= 1'b1;
			hid_q <= 1'b0;
		end
		if (state_q == ST_WA && div_done) begin
			sa_q <= div_quo;
		end
		if (state_q == ST_WB && div_done) begin
			sb_q <= div_quo;
		end
		if (state_q == ST_CHK && req_q == REQ_QUERY) begin
			ctr_q <= 1'b0;
			if (covered && !ctr_q && cur_q == end_q) begin
				hid_q <= 1'b1;
			end
		end
		if (state_q == ST_OUT && out_free) begin
			hidden <= hid_q;
		end
	end

endmodule

@@ rtl/core/aob_ram.sv @@
// generic single-port ram with registered read
module aob_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ rtl/core/aob_div.sv @@
// shared slope divider: (num * 65536) / den, one quotient bit a cycle, saturating
module aob_div import aob_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] num,
	input  logic [31:0]        den,
	output logic               done,
	output logic [31:0]        quo
);

	logic        run_q;
	logic        fin_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [49:0] dv_q;
	logic [33:0] mag;
	logic [33:0] trial;

	assign mag = num[33] ? 34'(-num) : 34'(num);
	assign trial = {1'b0, rem_q, dv_q[49]} - {2'b00, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= start ? ((num == '0) || (den == '0)) : (!run_q && fin_q);
			fin_q <= !start && run_q && (cnt_q == 6'd49);
			if (start) begin
				if (num != '0 && den != '0) begin
					run_q <= 1'b1;
					cnt_q <= '0;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd49) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// datapath: restoring division, quotient shifts in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[33];
			den_q <= den;
			rem_q <= '0;
			dv_q <= {mag, 16'h0000};
			if (num == '0) begin
				quo <= '0;
			end else if (den == '0) begin
				quo <= num[33] ? SLOPE_MIN : SLOPE_MAX;
			end
		end else if (run_q) begin
			if (!trial[33]) begin
				rem_q <= trial[31:0];
				dv_q <= {dv_q[48:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], dv_q[49]};
				dv_q <= {dv_q[48:0], 1'b0};
			end
		end else if (fin_q) begin
			if (dv_q[49:31] != '0) begin
				quo <= neg_q ? SLOPE_MIN : SLOPE_MAX;
			end else begin
				quo <= neg_q ? 32'(-dv_q[31:0]) : dv_q[31:0];
			end
		end
	end

endmodule
